// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising edge of i_clk, held off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

// ----- sv/jhms_pkg.sv -----
// ---------------------------------------------------------------------------
// jhms_pkg
// status codes, marker codes and result type of the jpeg header marker scan
// ---------------------------------------------------------------------------
package jhms_pkg;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MARKER = 3'd1;
    localparam logic [2:0] ST_SHORT_APP0 = 3'd2;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd3;
    localparam logic [2:0] ST_STREAM_END = 3'd4;

    localparam logic [15:0] MARKER_HIGH_MASK = 16'hff00;
    localparam logic [15:0] MARKER_APP0      = 16'hffe0;
    localparam logic [15:0] MARKER_SOF_FIRST = 16'hffc0;
    localparam logic [15:0] MARKER_SOF_LAST  = 16'hffcf;
    localparam logic [15:0] MARKER_DHT       = 16'hffc4;
    localparam logic [15:0] MARKER_JPG       = 16'hffc8;

    localparam logic [15:0] HEAD_LEN     = 16'd2;
    localparam logic [15:0] APP0_MIN_LEN = 16'd14;
    localparam int          HDR_BYTES    = 12;
    localparam logic [15:0] APP0_READ    = 16'd12;
    localparam logic [15:0] SOF_READ     = 16'd6;
    localparam logic [15:0] HEAD_READ    = 16'd4;

    localparam logic [7:0] JFIF_TAG [5] = '{8'h4a, 8'h46, 8'h49, 8'h46, 8'h00};
    localparam logic [7:0] UNITS_INCH = 8'd1;
    localparam logic [7:0] UNITS_CM   = 8'd2;

    // dots per cm to dpi: floor(v * 127 / 50) = floor(((v * 127) >> 1) / 25)
    localparam logic [6:0]  DPI_CM_MUL   = 7'd127;
    localparam logic [25:0] DIV25_RECIP  = 26'd42949673;
    localparam int          DIV25_SHIFT  = 30;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] bpp;
        logic        dpi_cm;
        logic [22:0] dpi_x;
        logic [22:0] dpi_y;
        logic        dpi_known;
    } t_result;

endpackage

// ----- sv/jpeg_header_marker_scan.sv -----
// ---------------------------------------------------------------------------
// jpeg_header_marker_scan
// walks jpeg marker segments a byte at a time and reports the frame header
// ---------------------------------------------------------------------------
// One stream byte is taken per clock, every clock, as long as the result
// path is not backed up. A scan starts with first_byte on the FF of the first
// marker after SOI and ends with one result: the frame size and bits per
// pixel on a start of frame, with a zero-size status if a dimension is zero,
// an error status on a bad marker, a short APP0 or a byte marked last before
// that. The held JFIF density goes along with every result. A result passes
// a middle register stage, which holds the parsed values and the density
// product, then the output register, which finishes the dots per cm conversion.
// The middle stage lets a byte be taken while a result waits at the output.
`include "assert_macros.svh"

module jpeg_header_marker_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [15:0] o_bits_per_pixel,
    output logic [17:0] o_dpi_horizontal,
    output logic [17:0] o_dpi_vertical,
    output logic        o_dpi_known
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_APP0,
        PH_SOF,
        PH_SKIP,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_marker, n_marker;
    logic [15:0] r_length, n_length;
    logic [15:0] r_dpi_x, n_dpi_x;
    logic [15:0] r_dpi_y, n_dpi_y;
    logic        r_dpi_cm, n_dpi_cm;
    logic        r_dpi_seen, n_dpi_seen;
    logic [7:0]  r_hdr [jhms_pkg::HDR_BYTES];

    logic        r_s1_valid;
    jhms_pkg::t_result r_s1, n_s1;
    logic        r_out_valid;
    jhms_pkg::t_result r_out, n_out;

    logic        hdr_we;
    logic [3:0]  hdr_idx;
    logic        res_valid;
    logic [2:0]  res_status;
    logic [15:0] res_width;
    logic [15:0] res_height;
    logic [15:0] res_bpp;
    logic [15:0] skip_len;
    logic        tag_ok;
    logic [15:0] app_x;
    logic [15:0] app_y;

    logic        in_xfer;
    logic        out_ready;
    logic        s1_move;
    logic [47:0] quot_x;
    logic [47:0] quot_y;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_marker   = r_marker;
        n_length   = r_length;
        n_dpi_x    = r_dpi_x;
        n_dpi_y    = r_dpi_y;
        n_dpi_cm   = r_dpi_cm;
        n_dpi_seen = r_dpi_seen;
        hdr_we     = 1'b0;
        hdr_idx    = r_count[3:0];
        res_valid  = 1'b0;
        res_status = jhms_pkg::ST_OK;
        res_width  = '0;
        res_height = '0;
        res_bpp    = '0;
        skip_len   = '0;
        tag_ok     = 1'b1;
        app_x      = {r_hdr[8], r_hdr[9]};
        app_y      = {r_hdr[10], i_data_byte};

        if (i_first_byte) begin
            n_phase    = PH_HEAD;
            n_count    = '0;
            n_marker   = '0;
            n_length   = '0;
            n_dpi_x    = '0;
            n_dpi_y    = '0;
            n_dpi_cm   = 1'b0;
            n_dpi_seen = 1'b0;
        end

        unique case (n_phase)
            PH_HEAD: begin
                if (n_count < 16'd2) begin
                    n_marker = {n_marker[7:0], i_data_byte};
                end else begin
                    n_length = {n_length[7:0], i_data_byte};
                end
                n_count = n_count + 16'd1;
                if (n_count >= jhms_pkg::HEAD_READ) begin
                    n_count = '0;
                    if ((n_marker & jhms_pkg::MARKER_HIGH_MASK)
                            != jhms_pkg::MARKER_HIGH_MASK) begin
                        res_valid  = 1'b1;
                        res_status = jhms_pkg::ST_BAD_MARKER;
                        n_phase    = PH_DONE;
                    end else if (n_marker == jhms_pkg::MARKER_APP0) begin
                        if (n_length < jhms_pkg::APP0_MIN_LEN) begin
                            res_valid  = 1'b1;
                            res_status = jhms_pkg::ST_SHORT_APP0;
                            n_phase    = PH_DONE;
                        end else begin
                            n_phase = PH_APP0;
                        end
                    end else if (n_marker >= jhms_pkg::MARKER_SOF_FIRST &&
                                 n_marker <= jhms_pkg::MARKER_SOF_LAST &&
                                 n_marker != jhms_pkg::MARKER_DHT &&
                                 n_marker != jhms_pkg::MARKER_JPG) begin
                        n_phase = PH_SOF;
                    end else begin
                        skip_len = (n_length >= jhms_pkg::HEAD_LEN) ?
                                   n_length - jhms_pkg::HEAD_LEN : 16'd0;
                        n_phase  = (skip_len == 16'd0) ? PH_HEAD : PH_SKIP;
                        n_count  = skip_len;
                    end
                end
            end
            PH_APP0: begin
                hdr_we  = 1'b1;
                hdr_idx = n_count[3:0];
                n_count = n_count + 16'd1;
                if (n_count >= jhms_pkg::APP0_READ) begin
                    for (int k = 0; k < 5; k++) begin
                        if (r_hdr[k] != jhms_pkg::JFIF_TAG[k]) begin
                            tag_ok = 1'b0;
                        end
                    end
                    if (tag_ok && (r_hdr[7] == jhms_pkg::UNITS_INCH ||
                                   r_hdr[7] == jhms_pkg::UNITS_CM)) begin
                        n_dpi_x    = app_x;
                        n_dpi_y    = app_y;
                        n_dpi_cm   = (r_hdr[7] == jhms_pkg::UNITS_CM);
                        n_dpi_seen = 1'b1;
                    end
                    skip_len = (n_length >= jhms_pkg::APP0_MIN_LEN) ?
                               n_length - jhms_pkg::APP0_MIN_LEN : 16'd0;
                    n_phase  = (skip_len == 16'd0) ? PH_HEAD : PH_SKIP;
                    n_count  = skip_len;
                end
            end
            PH_SOF: begin
                hdr_we  = 1'b1;
                hdr_idx = n_count[3:0];
                n_count = n_count + 16'd1;
                if (n_count >= jhms_pkg::SOF_READ) begin
                    res_valid  = 1'b1;
                    res_height = {r_hdr[1], r_hdr[2]};
                    res_width  = {r_hdr[3], r_hdr[4]};
                    res_bpp    = 16'(r_hdr[0]) * 16'(i_data_byte);
                    res_status = (res_width != 16'd0 && res_height != 16'd0) ?
                                 jhms_pkg::ST_OK : jhms_pkg::ST_ZERO_SIZE;
                    n_count    = '0;
                    n_phase    = PH_DONE;
                end
            end
            PH_SKIP: begin
                if (n_count != 16'd0) begin
                    n_count = n_count - 16'd1;
                end
                if (n_count == 16'd0) begin
                    n_phase = PH_HEAD;
                end
            end
            default: begin
            end
        endcase

        if (!res_valid && i_last_byte && (r_phase != PH_IDLE || i_first_byte) &&
                (r_phase != PH_DONE || i_first_byte)) begin
            res_valid  = 1'b1;
            res_status = jhms_pkg::ST_STREAM_END;
            n_count    = '0;
            n_phase    = PH_DONE;
        end
    end

    always_comb begin
        n_s1.status    = res_status;
        n_s1.width     = res_width;
        n_s1.height    = res_height;
        n_s1.bpp       = res_bpp;
        n_s1.dpi_cm    = n_dpi_cm;
        n_s1.dpi_x     = n_dpi_cm ? 23'(n_dpi_x) * 23'(jhms_pkg::DPI_CM_MUL) :
                                    23'(n_dpi_x);
        n_s1.dpi_y     = n_dpi_cm ? 23'(n_dpi_y) * 23'(jhms_pkg::DPI_CM_MUL) :
                                    23'(n_dpi_y);
        n_s1.dpi_known = n_dpi_seen;
    end

    assign quot_x = 48'(r_s1.dpi_x[22:1]) * 48'(jhms_pkg::DIV25_RECIP);
    assign quot_y = 48'(r_s1.dpi_y[22:1]) * 48'(jhms_pkg::DIV25_RECIP);

    always_comb begin
        n_out = r_s1;
        if (r_s1.dpi_cm) begin
            n_out.dpi_x = 23'(quot_x[jhms_pkg::DIV25_SHIFT +: 18]);
            n_out.dpi_y = 23'(quot_y[jhms_pkg::DIV25_SHIFT +: 18]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_marker    <= '0;
            r_length    <= '0;
            r_dpi_x     <= '0;
            r_dpi_y     <= '0;
            r_dpi_cm    <= 1'b0;
            r_dpi_seen  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase    <= n_phase;
                r_count    <= n_count;
                r_marker   <= n_marker;
                r_length   <= n_length;
                r_dpi_x    <= n_dpi_x;
                r_dpi_y    <= n_dpi_y;
                r_dpi_cm   <= n_dpi_cm;
                r_dpi_seen <= n_dpi_seen;
            end
            if (in_xfer && res_valid) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && hdr_we && hdr_idx < 4'(jhms_pkg::HDR_BYTES)) begin
            r_hdr[hdr_idx] <= i_data_byte;
        end
        if (in_xfer && res_valid) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_image_width    = r_out.width;
    assign o_image_height   = r_out.height;
    assign o_bits_per_pixel = r_out.bpp;
    assign o_dpi_horizontal = r_out.dpi_x[17:0];
    assign o_dpi_vertical   = r_out.dpi_y[17:0];
    assign o_dpi_known      = r_out.dpi_known;

    `ASSERT_IMPL(a_stall_needs_s1, o_in_stall, r_s1_valid && r_out_valid,
        "input stalled without a pending result")
    `ASSERT_IMPL(a_s1_held, r_s1_valid && r_out_valid && i_out_stall,
        ##1 r_s1_valid, "pending result dropped while output stalled")
    `ASSERT_IMPL(a_idle_silent,
        in_xfer && !i_first_byte && !r_s1_valid &&
        (r_phase == PH_IDLE || r_phase == PH_DONE),
        ##1 !r_s1_valid, "result produced outside a scan")
    `ASSERT_IMPL(a_ok_has_size, r_out_valid && r_out.status == jhms_pkg::ST_OK,
        r_out.width != 16'd0 && r_out.height != 16'd0,
        "ok status with a zero dimension")

endmodule
